>>> rtl/imufd_pkg.sv
`timescale 1ns / 1ps

package imufd_pkg;

  // frame bytes
  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC = 8'h51;
  localparam logic [7:0] TYPE_GYR = 8'h52;
  localparam logic [7:0] TYPE_ANG = 8'h53;

  // byte positions within a frame
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
  localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
  localparam logic [POS_W-1:0] POS_DATA0 = 4'd2;
  localparam logic [POS_W-1:0] POS_CSUM  = 4'd10;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 1'b1;

  localparam int unsigned ACCEL_W = 16;
  localparam int unsigned GYRO_W  = 12;
  localparam logic [ACCEL_W-1:0] ACCEL_SCALE_RST = 16'd40141;
  localparam logic [GYRO_W-1:0]  GYRO_RANGE_RST  = 12'd2000;

  // scaling constants
  localparam logic [16:0] ANGLE_MULT  = 17'd180;
  localparam logic [11:0] TEMP_MULT   = 12'd771;
  localparam logic [17:0] TEMP_OFFSET = 18'd9352;

  // result widths
  localparam int unsigned AXIS_W = 20;
  localparam int unsigned TEMP_W = 17;

  typedef enum logic [1:0] {
    KIND_ACC = 2'd0,
    KIND_GYR = 2'd1,
    KIND_ANG = 2'd2
  } kind_t;

  // completed frame handed from assembler to scaler
  typedef struct packed {
    logic        fire;
    kind_t       kind;
    logic [15:0] x_raw;
    logic [15:0] y_raw;
    logic [15:0] z_raw;
    logic [15:0] t_raw;
  } frame_t;

endpackage

>>> rtl/imufd_assembler.sv
`timescale 1ns / 1ps

module imufd_assembler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                out_busy,
  output imufd_pkg::frame_t   frame
);

  logic [imufd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  imufd_pkg::kind_t            kind_r, kind_nxt;
  logic [7:0][7:0]             payload_r;
  logic                        xfer;
  logic [2:0]                  data_idx;

  // only a checksum byte needs room in the result register
  assign in_ready = !((pos_r == imufd_pkg::POS_CSUM) && out_busy);
  assign xfer     = in_valid && in_ready;
  assign data_idx = 3'(pos_r - imufd_pkg::POS_DATA0);

  // framing next state
  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    kind_nxt = kind_r;
    if (xfer) begin
      if (pos_r == imufd_pkg::POS_HUNT || pos_r > imufd_pkg::POS_CSUM) begin
        pos_nxt = imufd_pkg::POS_HUNT;
        if (in_rx_byte == imufd_pkg::HDR_BYTE) begin
          sum_nxt = imufd_pkg::HDR_BYTE;
          pos_nxt = imufd_pkg::POS_TYPE;
        end
      end else if (pos_r == imufd_pkg::POS_TYPE) begin
        pos_nxt = imufd_pkg::POS_HUNT;
        case (in_rx_byte)
          imufd_pkg::TYPE_ACC: begin
            kind_nxt = imufd_pkg::KIND_ACC;
            sum_nxt  = sum_r + in_rx_byte;
            pos_nxt  = imufd_pkg::POS_DATA0;
          end
          imufd_pkg::TYPE_GYR: begin
            kind_nxt = imufd_pkg::KIND_GYR;
            sum_nxt  = sum_r + in_rx_byte;
            pos_nxt  = imufd_pkg::POS_DATA0;
          end
          imufd_pkg::TYPE_ANG: begin
            kind_nxt = imufd_pkg::KIND_ANG;
            sum_nxt  = sum_r + in_rx_byte;
            pos_nxt  = imufd_pkg::POS_DATA0;
          end
          default: pos_nxt = imufd_pkg::POS_HUNT;
        endcase
      end else if (pos_r < imufd_pkg::POS_CSUM) begin
        sum_nxt = sum_r + in_rx_byte;
        pos_nxt = pos_r + 1'b1;
      end else begin
        pos_nxt = imufd_pkg::POS_HUNT;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= imufd_pkg::POS_HUNT;
      sum_r  <= '0;
      kind_r <= imufd_pkg::KIND_ACC;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      kind_r <= kind_nxt;
    end
  end

  // payload capture, data positions only
  always_ff @(posedge clk) begin
    if (xfer && pos_r >= imufd_pkg::POS_DATA0 && pos_r < imufd_pkg::POS_CSUM) begin
      payload_r[data_idx] <= in_rx_byte;
    end
  end

  // frame completes on a matching checksum byte
  always_comb begin
    frame.fire  = xfer && (pos_r == imufd_pkg::POS_CSUM) && (in_rx_byte == sum_r);
    frame.kind  = kind_r;
    frame.x_raw = {payload_r[1], payload_r[0]};
    frame.y_raw = {payload_r[3], payload_r[2]};
    frame.z_raw = {payload_r[5], payload_r[4]};
    frame.t_raw = {payload_r[7], payload_r[6]};
  end

endmodule

>>> rtl/imufd_scaler.sv
`timescale 1ns / 1ps

module imufd_scaler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  imufd_pkg::frame_t                    frame,
  input  logic [imufd_pkg::ACCEL_W-1:0]        accel_scale,
  input  logic [imufd_pkg::GYRO_W-1:0]         gyro_range,
  output logic                                 out_busy,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_packet_kind,
  output logic signed [imufd_pkg::AXIS_W-1:0]  out_x_value,
  output logic signed [imufd_pkg::AXIS_W-1:0]  out_y_value,
  output logic signed [imufd_pkg::AXIS_W-1:0]  out_z_value,
  output logic signed [imufd_pkg::TEMP_W-1:0]  out_temperature_q8
);

  logic                                valid_r, valid_nxt;
  logic [1:0]                          kind_r;
  logic signed [imufd_pkg::AXIS_W-1:0] x_r, y_r, z_r;
  logic signed [imufd_pkg::TEMP_W-1:0] t_r;
  logic signed [16:0]                  mult;
  logic                                long_shift;
  logic signed [imufd_pkg::AXIS_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [27:0]                  t_prod;
  logic signed [17:0]                  t_sum;

  // floor shift of raw * mult, then clamp to the axis range
  function automatic logic signed [imufd_pkg::AXIS_W-1:0] scale_axis(
    input logic [15:0]        raw,
    input logic signed [16:0] m,
    input logic               acc
  );
    logic signed [32:0] prod;
    logic signed [25:0] sh;
    prod = $signed(raw) * m;
    if (acc) begin
      sh = {{8{prod[32]}}, prod[32:15]};
    end else begin
      sh = prod[32:7];
    end
    if (sh > 26'sd524287) begin
      scale_axis = 20'sh7FFFF;
    end else if (sh < -26'sd524288) begin
      scale_axis = 20'sh80000;
    end else begin
      scale_axis = sh[19:0];
    end
  endfunction

  // multiplier select by kind
  always_comb begin
    case (frame.kind)
      imufd_pkg::KIND_ACC: begin
        mult       = $signed({1'b0, accel_scale});
        long_shift = 1'b1;
      end
      imufd_pkg::KIND_GYR: begin
        mult       = $signed({5'b0, gyro_range});
        long_shift = 1'b0;
      end
      default: begin
        mult       = $signed(imufd_pkg::ANGLE_MULT);
        long_shift = 1'b0;
      end
    endcase
  end

  // axis and temperature datapath
  always_comb begin
    x_nxt  = scale_axis(frame.x_raw, mult, long_shift);
    y_nxt  = scale_axis(frame.y_raw, mult, long_shift);
    z_nxt  = scale_axis(frame.z_raw, mult, long_shift);
    t_prod = $signed(frame.t_raw) * $signed(imufd_pkg::TEMP_MULT);
    t_sum  = t_prod[27:10] + $signed(imufd_pkg::TEMP_OFFSET);
  end

  // result register holds until the transfer
  assign valid_nxt = frame.fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  assign out_busy  = valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.fire) begin
      kind_r <= frame.kind;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      t_r    <= t_sum[16:0];
    end
  end

  assign out_valid          = valid_r;
  assign out_packet_kind    = kind_r;
  assign out_x_value        = x_r;
  assign out_y_value        = y_r;
  assign out_z_value        = z_r;
  assign out_temperature_q8 = t_r;

endmodule

>>> rtl/imu_serial_frame_decoder.sv
`timescale 1ns / 1ps

// channel  direction  handshake           payload
// in       input      in_valid/in_ready   in_rx_byte
// out      output     out_valid/out_ready kind, x, y, z, temperature
// cfg      input      cfg_wr_en           cfg_index, cfg_data
//
// one byte is taken per cycle unless held off; a result registers in the cycle
// after its checksum byte, past the multiply stage, and holds until its transfer
// while a result waits, only a checksum byte is held off; other bytes keep flowing
// rst_n is synchronous: framing returns to header hunt and registers reload defaults

module imu_serial_frame_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_packet_kind,
  output logic signed [imufd_pkg::AXIS_W-1:0]  out_x_value,
  output logic signed [imufd_pkg::AXIS_W-1:0]  out_y_value,
  output logic signed [imufd_pkg::AXIS_W-1:0]  out_z_value,
  output logic signed [imufd_pkg::TEMP_W-1:0]  out_temperature_q8,
  input  logic                                 cfg_wr_en,
  input  logic [imufd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imufd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [imufd_pkg::ACCEL_W-1:0] accel_scale_r;
  logic [imufd_pkg::GYRO_W-1:0]  gyro_range_r;
  imufd_pkg::frame_t             frame;
  logic                          out_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_scale_r <= imufd_pkg::ACCEL_SCALE_RST;
      gyro_range_r  <= imufd_pkg::GYRO_RANGE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        imufd_pkg::CFG_ACCEL_SCALE: accel_scale_r <= cfg_data;
        imufd_pkg::CFG_GYRO_RANGE:  gyro_range_r  <= cfg_data[imufd_pkg::GYRO_W-1:0];
        default: ;
      endcase
    end
  end

  imufd_assembler u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_busy   (out_busy),
    .frame      (frame)
  );

  imufd_scaler u_scl (
    .clk                (clk),
    .rst_n              (rst_n),
    .frame              (frame),
    .accel_scale        (accel_scale_r),
    .gyro_range         (gyro_range_r),
    .out_busy           (out_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_packet_kind    (out_packet_kind),
    .out_x_value        (out_x_value),
    .out_y_value        (out_y_value),
    .out_z_value        (out_z_value),
    .out_temperature_q8 (out_temperature_q8)
  );

endmodule

>>> rtl/imufd_checker.sv
`timescale 1ns / 1ps

module imufd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [1:0]                           out_packet_kind,
  input logic signed [imufd_pkg::AXIS_W-1:0]  out_x_value,
  input logic signed [imufd_pkg::AXIS_W-1:0]  out_y_value,
  input logic signed [imufd_pkg::AXIS_W-1:0]  out_z_value,
  input logic signed [imufd_pkg::TEMP_W-1:0]  out_temperature_q8
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_value) &&
      $stable(out_y_value) && $stable(out_z_value) &&
      $stable(out_temperature_q8) && $stable(out_packet_kind))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input is only held off by a waiting result
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // kind code is one of the three frame types
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_packet_kind == imufd_pkg::KIND_ACC) ||
      (out_packet_kind == imufd_pkg::KIND_GYR) ||
      (out_packet_kind == imufd_pkg::KIND_ANG))
    else $error("illegal packet kind");

  // temperature stays within the reachable span
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_q8 >= -17'sd16384) &&
      (out_temperature_q8 <= 17'sd34816))
    else $error("temperature out of range");

endmodule

bind imu_serial_frame_decoder imufd_checker u_imufd_checker (.*);

>>> sim/tb_imu_serial_frame_decoder.sv
`timescale 1ns / 1ps

module tb_imu_serial_frame_decoder;
  import imufd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 12;
  localparam int PHASE_BYTES = 270;

  // one decoded sensor reading
  typedef struct {
    kind_t                     kind;
    logic signed [AXIS_W-1:0]  x;
    logic signed [AXIS_W-1:0]  y;
    logic signed [AXIS_W-1:0]  z;
    logic signed [TEMP_W-1:0]  temp;
  } imu_reading_t;

  // frame tracker that mirrors the decoder and holds the readings still owed
  class imu_frame_scoreboard;
    logic [POS_W-1:0]   pos;
    logic [7:0]         sum;
    kind_t              kind;
    logic [7:0]         payload [8];
    logic [ACCEL_W-1:0] accel_scale;
    logic [GYRO_W-1:0]  gyro_range;
    imu_reading_t       owed [$];
    int                 errors;

    function new();
      pos = POS_HUNT;
      sum = 8'd0;
      kind = KIND_ACC;
      foreach (payload[i]) payload[i] = 8'd0;
      accel_scale = ACCEL_SCALE_RST;
      gyro_range = GYRO_RANGE_RST;
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_ACCEL_SCALE) accel_scale = value[ACCEL_W-1:0];
      else if (idx == CFG_GYRO_RANGE) gyro_range = value[GYRO_W-1:0];
    endfunction

    function logic [15:0] word_at(int k);
      return {payload[2*k+1], payload[2*k]};
    endfunction

    // scale one raw word by the frame kind, floor shift, then clamp to 20 bits
    function logic signed [AXIS_W-1:0] scale_axis(logic [15:0] raw_u);
      longint raw;
      longint mult;
      longint q;
      raw = $signed(raw_u);
      case (kind)
        KIND_ACC: begin
          mult = accel_scale;
          q = (raw * mult) >>> 15;
        end
        KIND_GYR: begin
          mult = gyro_range;
          q = (raw * mult) >>> 7;
        end
        default: begin
          q = (raw * 180) >>> 7;
        end
      endcase
      if (q > 524287) q = 524287;
      if (q < -524288) q = -524288;
      return q[AXIS_W-1:0];
    endfunction

    function logic signed [TEMP_W-1:0] scale_temp(logic [15:0] raw_u);
      longint raw;
      longint t;
      raw = $signed(raw_u);
      t = ((raw * 771) >>> 10) + 9352;
      return t[TEMP_W-1:0];
    endfunction

    // one accepted byte advances the frame state
    function void note_byte(logic [7:0] b);
      imu_reading_t r;
      if (pos == POS_HUNT || pos > POS_CSUM) begin
        pos = POS_HUNT;
        if (b == HDR_BYTE) begin
          sum = HDR_BYTE;
          pos = POS_TYPE;
        end
      end else if (pos == POS_TYPE) begin
        if (b == TYPE_ACC || b == TYPE_GYR || b == TYPE_ANG) begin
          kind = kind_t'(b[1:0] - 2'd1);
          sum = sum + b;
          pos = POS_DATA0;
        end else begin
          pos = POS_HUNT;
        end
      end else if (pos < POS_CSUM) begin
        payload[pos - POS_DATA0] = b;
        sum = sum + b;
        pos = pos + 1'b1;
      end else begin
        pos = POS_HUNT;
        if (b == sum) begin
          r.kind = kind;
          r.x = scale_axis(word_at(0));
          r.y = scale_axis(word_at(1));
          r.z = scale_axis(word_at(2));
          r.temp = scale_temp(word_at(3));
          owed.push_back(r);
        end
      end
    endfunction

    // compare one transferred reading with the oldest one owed
    function void check_reading(logic [1:0] k, logic signed [AXIS_W-1:0] x,
                                logic signed [AXIS_W-1:0] y, logic signed [AXIS_W-1:0] z,
                                logic signed [TEMP_W-1:0] t);
      imu_reading_t w;
      if (owed.size() == 0) begin
        report("unexpected reading, kind", k, -1);
        return;
      end
      w = owed.pop_front();
      if (k !== w.kind) report("packet_kind", k, w.kind);
      if (x !== w.x) report("x_value", x, w.x);
      if (y !== w.y) report("y_value", y, w.y);
      if (z !== w.z) report("z_value", z, w.z);
      if (t !== w.temp) report("temperature_q8", t, w.temp);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_rx_byte = 8'd0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_packet_kind;
  logic signed [AXIS_W-1:0] out_x_value;
  logic signed [AXIS_W-1:0] out_y_value;
  logic signed [AXIS_W-1:0] out_z_value;
  logic signed [TEMP_W-1:0] out_temperature_q8;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  imu_frame_scoreboard sb = new();
  bit idle_on = 1'b1;
  int quiet_cycles = 0;
  int frame_bytes_sent = 0;

  imu_serial_frame_decoder u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_packet_kind    (out_packet_kind),
    .out_x_value        (out_x_value),
    .out_y_value        (out_y_value),
    .out_z_value        (out_z_value),
    .out_temperature_q8 (out_temperature_q8),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // transfer monitor on both channels, plus the no-progress counter
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready)
        sb.check_reading(out_packet_kind, out_x_value, out_y_value, out_z_value,
                         out_temperature_q8);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // result side back-pressure in short bursts
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one byte transfer, with an optional gap in front of it
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // header, type, four little-endian words and checksum; cut stops early
  task automatic send_frame(input logic [7:0] type_byte, input logic [63:0] words,
                            input bit corrupt, input int cut);
    logic [7:0] frame [11];
    logic [7:0] s;
    int n;
    frame[0] = HDR_BYTE;
    frame[1] = type_byte;
    for (int i = 0; i < 8; i++) frame[2 + i] = words[8*i +: 8];
    s = 8'd0;
    for (int i = 0; i < 10; i++) s = s + frame[i];
    frame[10] = corrupt ? (s ^ (8'd1 << $urandom_range(0, 7))) : s;
    n = (cut > 0 && cut < 11) ? cut : 11;
    for (int i = 0; i < n; i++) begin
      send_byte(frame[i]);
      frame_bytes_sent++;
    end
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_words();
    return {pick_word(), pick_word(), pick_word(), pick_word()};
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 2))
      0: return TYPE_ACC;
      1: return TYPE_GYR;
      default: return TYPE_ANG;
    endcase
  endfunction

  // mostly clean frames, with corrupted, cut short, misframed ones and stray bytes mixed in
  task automatic send_random_sequence();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_frame(pick_type(), pick_words(), 1'b0, 0);
    end else if (r < 82) begin
      send_frame(pick_type(), pick_words(), 1'b1, 0);
    end else if (r < 87) begin
      send_frame(pick_type(), pick_words(), 1'b0, $urandom_range(1, 10));
    end else if (r < 92) begin
      b = ($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom);
      while (b == TYPE_ACC || b == TYPE_GYR || b == TYPE_ANG) b = 8'($urandom);
      send_byte(HDR_BYTE);
      send_byte(b);
      frame_bytes_sent += 2;
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = frame_bytes_sent;
    while (frame_bytes_sent - start < target) send_random_sequence();
  endtask

  // stop sending, wait for every owed reading, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_register(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: skipped noise, header taken as type, field extremes, bad checksum
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_frame(TYPE_ACC, {16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF}, 1'b0, 0);
    send_frame(TYPE_GYR, {16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000}, 1'b0, 0);
    send_frame(TYPE_ANG, {16'h0000, 16'h0001, 16'h8000, 16'h7FFF}, 1'b0, 0);
    send_frame(TYPE_ACC, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 1'b1, 0);
    run_random(PHASE_BYTES);

    // later phases at other register settings, the last one without idling
    for (int p = 1; p < 6; p++) begin
      drain_results();
      case (p)
        1: begin
          write_register(CFG_ACCEL_SCALE, 16'hFFFF);
          write_register(CFG_GYRO_RANGE, 16'd4000);
          send_frame(TYPE_GYR, {16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF}, 1'b0, 0);
        end
        2: begin
          write_register(CFG_ACCEL_SCALE, 16'd1);
          write_register(CFG_GYRO_RANGE, 16'd1);
        end
        3: begin
          write_register(CFG_ACCEL_SCALE, 16'd0);
          write_register(CFG_GYRO_RANGE, 16'd0);
        end
        4: begin
          write_register(CFG_ACCEL_SCALE, 16'($urandom));
          write_register(CFG_GYRO_RANGE, 16'($urandom) | 16'hF000);
        end
        default: begin
          write_register(CFG_ACCEL_SCALE, ACCEL_SCALE_RST);
          write_register(CFG_GYRO_RANGE, 16'($urandom_range(1, 4000)));
          idle_on = 1'b0;
        end
      endcase
      run_random(PHASE_BYTES);
    end

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/imufd_pkg.sv
rtl/imufd_assembler.sv
rtl/imufd_scaler.sv
rtl/imu_serial_frame_decoder.sv
rtl/imufd_checker.sv
sim/tb_imu_serial_frame_decoder.sv
